[rtl/upt_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the
// unsorted priority table. No dependencies.
package upt_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_MAX    = 3'd2,
        OP_MIN    = 3'd3,
        OP_SEARCH = 3'd4
    } upt_op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_REFUSED   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } upt_status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic seed;
        logic insert;
        logic refuse;
        logic nop;
        logic scan_init;
        logic scan_step;
        logic scan_finish;
        logic move_rd;
        logic move_wr;
        logic out_load;
    } upt_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic    seeded;
        logic    single;
        logic    scan_done;
        logic    scan_hit;
        logic    out_free;
        upt_op_t op;
    } upt_stat_t;

endpackage

[rtl/unsorted_priority_table.sv]
// Unsorted priority table: an unordered table of up to DEPTH signed values
// with insert, remove, max, min and search. One result per item. Holds the
// first_value register; the first item after reset seeds entry 0 with it
// in an extra seed state. Insert, unused opcodes and a remove on a one-entry
// table (refused) go from dispatch straight to the result; max, min, search
// and a remove miss scan the entries, since the entry RAM has one read port
// and the scan reads one entry a cycle; a remove hit then fetches the last
// entry and writes it into the hole. A finished result waits in the output
// register, so the next item is taken while it is still stalled.
// Depends on upt_pkg, upt_ctrl, upt_dp and upt_ram.
module unsorted_priority_table (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input item channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [2:0]                           opcode,
    input  logic signed [upt_pkg::DATA_WIDTH-1:0] operand_value,
    // configuration: first_value register
    input  logic                                 first_value_wr_en,
    input  logic signed [upt_pkg::DATA_WIDTH-1:0] first_value_wr_data,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           status,
    output logic signed [upt_pkg::DATA_WIDTH-1:0] result_value,
    output logic [upt_pkg::CNT_W-1:0]            entry_count
);
    import upt_pkg::*;

    upt_cmd_t  cmd;
    upt_stat_t stat;

    // Sequence each item: seed, dispatch, scan, move, hand off the result.
    upt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the table, the fill count and the output register.
    upt_dp u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .stat                (stat),
        .opcode              (opcode),
        .operand_value       (operand_value),
        .first_value_wr_en   (first_value_wr_en),
        .first_value_wr_data (first_value_wr_data),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .status              (status),
        .result_value        (result_value),
        .entry_count         (entry_count)
    );

    // A delivered result always reports a seeded, in-range table.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (entry_count != '0 && entry_count <= CNT_W'(DEPTH)))
        else $error("entry_count out of range on a valid result");

    // Only one source writes the entry RAM at a time.
    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.seed, cmd.insert, cmd.move_wr}))
        else $error("conflicting RAM write commands");

    // The hole fill must use the data fetched in the cycle before.
    a_move_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.move_wr |-> $past(cmd.move_rd))
        else $error("hole write without preceding read of last entry");

    // After a transfer in, stall until the item is finished.
    a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> in_stall)
        else $error("input not stalled while an item is in progress");

endmodule

[rtl/upt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module upt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/upt_ctrl.sv]
// Sequencing state machine for the unsorted priority table.
// Depends on upt_pkg for the command and status structs.
module upt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  upt_pkg::upt_stat_t stat,
    output upt_pkg::upt_cmd_t  cmd
);
    import upt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED,
        S_DISPATCH,
        S_SCAN,
        S_MOVE_RD,
        S_MOVE_WR,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.seeded ? S_DISPATCH : S_SEED;
                end
            end
            S_SEED:
            begin
                cmd.seed   = 1'b1;
                state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                case (stat.op)
                    OP_INSERT:
                    begin
                        cmd.insert = 1'b1;
                        state_next = S_DONE;
                    end
                    OP_REMOVE:
                    begin
                        if (stat.single)
                        begin
                            cmd.refuse = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                    OP_MAX, OP_MIN, OP_SEARCH:
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                    default:
                    begin
                        cmd.nop    = 1'b1;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    cmd.scan_finish = 1'b1;
                    state_next = (stat.op == OP_REMOVE && stat.scan_hit) ? S_MOVE_RD : S_DONE;
                end
            end
            S_MOVE_RD:
            begin
                cmd.move_rd = 1'b1;
                state_next  = S_MOVE_WR;
            end
            S_MOVE_WR:
            begin
                cmd.move_wr = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/upt_dp.sv]
// Datapath of the unsorted priority table: item and result registers, fill
// count, scan pipeline and entry RAM. Depends on upt_pkg and upt_ram.
module upt_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  upt_pkg::upt_cmd_t                    cmd,
    output upt_pkg::upt_stat_t                   stat,
    input  logic [2:0]                           opcode,
    input  logic signed [upt_pkg::DATA_WIDTH-1:0] operand_value,
    input  logic                                 first_value_wr_en,
    input  logic signed [upt_pkg::DATA_WIDTH-1:0] first_value_wr_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           status,
    output logic signed [upt_pkg::DATA_WIDTH-1:0] result_value,
    output logic [upt_pkg::CNT_W-1:0]            entry_count
);
    import upt_pkg::*;

    // control state
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  evv_reg, evv_next;
    logic                  out_valid_reg, out_valid_next;
    logic signed [DATA_WIDTH-1:0] first_value_reg;

    // payload
    upt_op_t               op_reg;
    logic signed [DATA_WIDTH-1:0] val_reg;
    logic [CNT_W-1:0]      idx_reg;
    logic [ADDR_W-1:0]     ev_idx_reg;
    logic [ADDR_W-1:0]     hole_reg;
    logic signed [DATA_WIDTH-1:0] acc_reg, acc_next;
    upt_status_t           res_status_reg;
    logic signed [DATA_WIDTH-1:0] res_value_reg;
    upt_status_t           out_status_reg;
    logic signed [DATA_WIDTH-1:0] out_value_reg;
    logic [CNT_W-1:0]      out_count_reg;

    // RAM ports
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic signed [DATA_WIDTH-1:0] ram_rdata;

    logic [CNT_W-1:0]      count_m1;
    logic                  full;
    logic                  issue;
    logic                  last;
    logic                  match;
    logic                  better;

    upt_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign count_m1 = count_reg - CNT_W'(1);
    assign full     = (count_reg >= CNT_W'(DEPTH));
    assign issue    = cmd.scan_step && (idx_reg < count_reg);
    assign last     = (CNT_W'(ev_idx_reg) == count_m1);
    assign match    = (op_reg == OP_SEARCH || op_reg == OP_REMOVE) && (ram_rdata == val_reg);
    assign better   = (op_reg == OP_MAX) ? (ram_rdata > acc_reg) : (ram_rdata < acc_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (evv_reg && (ev_idx_reg == '0 || better))
        begin
            acc_next = ram_rdata;
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = count_reg[ADDR_W-1:0];
        ram_wdata = val_reg;
        if (cmd.seed)
        begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = first_value_reg;
        end
        else if (cmd.insert && !full)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.move_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = hole_reg;
            ram_wdata = ram_rdata;
        end
    end

    assign ram_raddr = cmd.move_rd ? count_m1[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];

    always_comb
    begin
        count_next = count_reg;
        if (cmd.seed)
        begin
            count_next = CNT_W'(1);
        end
        else if (cmd.insert && !full)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.move_wr)
        begin
            count_next = count_m1;
        end
    end

    assign evv_next = issue;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            evv_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            first_value_reg <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            evv_reg       <= evv_next;
            out_valid_reg <= out_valid_next;
            if (first_value_wr_en)
            begin
                first_value_reg <= first_value_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= upt_op_t'(opcode);
            val_reg <= operand_value;
        end
        if (cmd.scan_init)
        begin
            idx_reg <= '0;
        end
        else if (issue)
        begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
        if (issue)
        begin
            ev_idx_reg <= idx_reg[ADDR_W-1:0];
        end
        acc_reg <= acc_next;
        if (cmd.insert)
        begin
            res_status_reg <= full ? ST_FULL : ST_OK;
            res_value_reg  <= '0;
        end
        else if (cmd.refuse)
        begin
            res_status_reg <= ST_REFUSED;
            res_value_reg  <= '0;
        end
        else if (cmd.nop)
        begin
            res_status_reg <= ST_OK;
            res_value_reg  <= '0;
        end
        else if (cmd.scan_finish)
        begin
            hole_reg <= ev_idx_reg;
            case (op_reg)
                OP_MAX, OP_MIN:
                begin
                    res_status_reg <= ST_OK;
                    res_value_reg  <= acc_next;
                end
                OP_SEARCH:
                begin
                    res_status_reg <= match ? ST_OK : ST_NOT_FOUND;
                    res_value_reg  <= match ? val_reg : '0;
                end
                default:
                begin
                    res_status_reg <= match ? ST_OK : ST_NOT_FOUND;
                    res_value_reg  <= '0;
                end
            endcase
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign stat.seeded    = (count_reg != '0);
    assign stat.single    = (count_reg == CNT_W'(1));
    assign stat.scan_done = evv_reg && (last || match);
    assign stat.scan_hit  = match;
    assign stat.out_free  = !out_valid_reg || !out_stall;
    assign stat.op        = op_reg;

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign result_value = out_value_reg;
    assign entry_count  = out_count_reg;

endmodule
